[hw/rtl/tss_pkg.sv]
// shared constants, types and reciprocal table for the taylor series sine block
package tss_pkg;

    // defaults for the top level parameters
    localparam int MAX_TERMS_DEF = 15;
    localparam int FRAC_BITS_DEF = 28;

    // port field widths
    localparam int ANGLE_W = 32;
    localparam int COUNT_W = 4;
    localparam int OUT_W   = 48;

    // fixed point formats of the ports and of the reciprocal table
    localparam int IN_FRAC    = 28;
    localparam int OUT_FRAC   = 28;
    localparam int RECIP_BITS = 62;

    // internal magnitudes and signed sums
    localparam int MAG_W = 63;
    localparam int SUM_W = 64;

    // multiplier array: word size, cell count, operand and product widths
    localparam int DIG_W     = 32;
    localparam int NUM_CELLS = 2;
    localparam int OPND_W    = DIG_W * NUM_CELLS;
    localparam int PROD_W    = 2 * OPND_W;

    // saturated output codes
    localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // reciprocals of (2i)(2i+1) for i = 1..32, unsigned q0.62, rounded to nearest
    localparam int RECIP_DEPTH = 32;
    localparam int RECIP_IDX_W = 5;
    localparam logic [63:0] ONE_Q62 = 64'd1 << RECIP_BITS;

    localparam logic [MAG_W-1:0] RECIP_Q62 [RECIP_DEPTH] = '{
        MAG_W'((ONE_Q62 + 64'd3) / 64'd6),
        MAG_W'((ONE_Q62 + 64'd10) / 64'd20),
        MAG_W'((ONE_Q62 + 64'd21) / 64'd42),
        MAG_W'((ONE_Q62 + 64'd36) / 64'd72),
        MAG_W'((ONE_Q62 + 64'd55) / 64'd110),
        MAG_W'((ONE_Q62 + 64'd78) / 64'd156),
        MAG_W'((ONE_Q62 + 64'd105) / 64'd210),
        MAG_W'((ONE_Q62 + 64'd136) / 64'd272),
        MAG_W'((ONE_Q62 + 64'd171) / 64'd342),
        MAG_W'((ONE_Q62 + 64'd210) / 64'd420),
        MAG_W'((ONE_Q62 + 64'd253) / 64'd506),
        MAG_W'((ONE_Q62 + 64'd300) / 64'd600),
        MAG_W'((ONE_Q62 + 64'd351) / 64'd702),
        MAG_W'((ONE_Q62 + 64'd406) / 64'd812),
        MAG_W'((ONE_Q62 + 64'd465) / 64'd930),
        MAG_W'((ONE_Q62 + 64'd528) / 64'd1056),
        MAG_W'((ONE_Q62 + 64'd595) / 64'd1190),
        MAG_W'((ONE_Q62 + 64'd666) / 64'd1332),
        MAG_W'((ONE_Q62 + 64'd741) / 64'd1482),
        MAG_W'((ONE_Q62 + 64'd820) / 64'd1640),
        MAG_W'((ONE_Q62 + 64'd903) / 64'd1806),
        MAG_W'((ONE_Q62 + 64'd990) / 64'd1980),
        MAG_W'((ONE_Q62 + 64'd1081) / 64'd2162),
        MAG_W'((ONE_Q62 + 64'd1176) / 64'd2352),
        MAG_W'((ONE_Q62 + 64'd1275) / 64'd2550),
        MAG_W'((ONE_Q62 + 64'd1378) / 64'd2756),
        MAG_W'((ONE_Q62 + 64'd1485) / 64'd2970),
        MAG_W'((ONE_Q62 + 64'd1596) / 64'd3192),
        MAG_W'((ONE_Q62 + 64'd1711) / 64'd3422),
        MAG_W'((ONE_Q62 + 64'd1830) / 64'd3660),
        MAG_W'((ONE_Q62 + 64'd1953) / 64'd3906),
        MAG_W'((ONE_Q62 + 64'd2080) / 64'd4160)
    };

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_PROD,
        S_RECIP,
        S_FINAL
    } t_state;

    // controls of one multiplier cell
    typedef struct packed {
        logic load;
        logic run;
    } t_cell_ctl;

    // request to the multiplier
    typedef struct packed {
        logic start;
        logic recip_sh;
    } t_mul_ctl;

endpackage

[hw/rtl/taylor_series_sine.sv]
// top level of the taylor series sine block: term sequencer, sum and output register
//
// Computes sin(x) as the truncated series x - x^3/3! + x^5/5! - ... up to term index
// term_count (clamped to MAX_TERMS), angle in signed Q4.28, result in signed Q20.28
// saturated to 48 bits. Work is done in sign and magnitude with FRAC_BITS fraction
// bits; every product rounds to nearest with ties away from zero. All products go
// through one multiplier built as a row of two 32-bit word cells. One item is worked
// at a time: x squared, then two products per term. The result is loaded into the
// output register once that register is free, as the sequencer returns to idle,
// and from then on the next item can be taken. A finished result waits in the output
// register while the next item is taken and worked.
module taylor_series_sine
    import tss_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [COUNT_W-1:0]       i_term_count,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_sine_value
);

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int QSH_UP = (OUT_FRAC > FRAC_BITS) ? OUT_FRAC - FRAC_BITS : 0;
    localparam int QW     = MAG_W + QSH_UP;

    localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI;

    t_state                  r_state, n_state;
    logic [MAG_W-1:0]        r_xmag, n_xmag;
    logic [MAG_W-1:0]        r_x2, n_x2;
    logic                    r_term_neg, n_term_neg;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]        r_n, n_n;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_W-1:0]        r_out_val, n_out_val;

    t_mul_ctl                mul_ctl;
    logic [MAG_W-1:0]        mul_a;
    logic [MAG_W-1:0]        mul_b;
    logic                    mul_done;
    logic [MAG_W-1:0]        mul_mag;

    logic [ANGLE_W-1:0]      ang_mag;
    logic [MAG_W-1:0]        x_mag;
    logic [SUM_W-1:0]        x_ext;
    logic signed [SUM_W-1:0] x_signed;
    logic [CNT_W-1:0]        n_in;
    logic [RECIP_IDX_W-1:0]  recip_idx;

    logic [SUM_W-1:0]        term_ext;
    logic signed [SUM_W-1:0] term_s;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;

    logic [SUM_W-1:0]        sum_abs;
    logic [MAG_W-1:0]        sum_mag;
    logic [QW-1:0]           q_mag;
    logic                    q_big;
    logic [OUT_W-1:0]        q_out;

    // angle magnitude rescaled to the internal format
    assign ang_mag = i_angle[ANGLE_W-1] ? ANGLE_W'(-i_angle) : ANGLE_W'(i_angle);

    if (FRAC_BITS >= IN_FRAC) begin : g_x_up
        assign x_mag = MAG_W'(ang_mag) << (FRAC_BITS - IN_FRAC);
    end else begin : g_x_dn
        localparam int XSH = IN_FRAC - FRAC_BITS;
        assign x_mag = MAG_W'(ang_mag >> XSH) + MAG_W'(ang_mag[XSH-1]);
    end

    assign x_ext    = {1'b0, x_mag};
    assign x_signed = i_angle[ANGLE_W-1] ? -$signed(x_ext) : $signed(x_ext);

    // term count limited to the configured maximum
    assign n_in = (CMP_W'(i_term_count) > CMP_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                             : CNT_W'(i_term_count);

    assign recip_idx = RECIP_IDX_W'(r_i - CNT_W'(1));

    // new term with flipped sign, added to the sum with saturation
    always_comb begin
        term_ext = {1'b0, mul_mag};
        term_s   = r_term_neg ? $signed(term_ext) : -$signed(term_ext);
        sum_wide = $signed({r_sum[SUM_W-1], r_sum}) + $signed({term_s[SUM_W-1], term_s});
        if (sum_wide > SUM_HI) begin
            sum_sat = SUM_HI[SUM_W-1:0];
        end else if (sum_wide < SUM_LO) begin
            sum_sat = SUM_LO[SUM_W-1:0];
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // sum rescaled to the output format
    assign sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign sum_mag = sum_abs[MAG_W-1:0];

    if (FRAC_BITS <= OUT_FRAC) begin : g_q_up
        assign q_mag = QW'(sum_mag) << QSH_UP;
    end else begin : g_q_dn
        localparam int QSH = FRAC_BITS - OUT_FRAC;
        assign q_mag = QW'(sum_mag >> QSH) + QW'(sum_mag[QSH-1]);
    end

    // saturate to the 48-bit output range
    always_comb begin
        q_big = |q_mag[QW-1:OUT_W-1];
        if (r_sum[SUM_W-1]) begin
            q_out = q_big ? OUT_NEG_MIN : (OUT_W'(0) - q_mag[OUT_W-1:0]);
        end else begin
            q_out = q_big ? OUT_POS_MAX : q_mag[OUT_W-1:0];
        end
    end

    // shared multiplier
    tss_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_mag   (mul_mag)
    );

    // sequencer: next state and multiplier requests
    always_comb begin
        n_state     = r_state;
        n_xmag      = r_xmag;
        n_x2        = r_x2;
        n_term_neg  = r_term_neg;
        n_sum       = r_sum;
        n_i         = r_i;
        n_n         = r_n;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_val   = r_out_val;
        mul_ctl     = '0;
        mul_a       = r_xmag;
        mul_b       = r_x2;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_xmag        = x_mag;
                    n_term_neg    = i_angle[ANGLE_W-1];
                    n_sum         = x_signed;
                    n_n           = n_in;
                    n_i           = CNT_W'(1);
                    mul_ctl.start = 1'b1;
                    mul_a         = x_mag;
                    mul_b         = x_mag;
                    n_state       = S_SQUARE;
                end
            end
            S_SQUARE: begin
                if (mul_done) begin
                    n_x2 = mul_mag;
                    if (r_n == '0) begin
                        n_state = S_FINAL;
                    end else begin
                        mul_ctl.start = 1'b1;
                        mul_a         = r_xmag;
                        mul_b         = mul_mag;
                        n_state       = S_PROD;
                    end
                end
            end
            S_PROD: begin
                if (mul_done) begin
                    mul_ctl.start    = 1'b1;
                    mul_ctl.recip_sh = 1'b1;
                    mul_a            = mul_mag;
                    mul_b            = RECIP_Q62[recip_idx];
                    n_state          = S_RECIP;
                end
            end
            S_RECIP: begin
                if (mul_done) begin
                    n_term_neg = ~r_term_neg;
                    n_sum      = sum_sat;
                    n_i        = r_i + CNT_W'(1);
                    if (r_i == r_n) begin
                        n_state = S_FINAL;
                    end else begin
                        mul_ctl.start = 1'b1;
                        mul_a         = mul_mag;
                        mul_b         = r_x2;
                        n_state       = S_PROD;
                    end
                end
            end
            S_FINAL: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_val   = q_out;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // working values and output register
    always_ff @(posedge i_clk) begin
        r_xmag     <= n_xmag;
        r_x2       <= n_x2;
        r_term_neg <= n_term_neg;
        r_sum      <= n_sum;
        r_i        <= n_i;
        r_n        <= n_n;
        r_out_val  <= n_out_val;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sine_value = $signed(r_out_val);

endmodule

[hw/rtl/tss_cell.sv]
// one word cell of the multiplier array: holds one operand word, a partial sum and a carry
module tss_cell
    import tss_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [DIG_W-1:0] i_a_dig,
    input  logic [DIG_W-1:0] i_b_dig,
    input  logic [DIG_W-1:0] i_s_in,
    output logic [DIG_W-1:0] o_s
);

    localparam int ACC_W = 2 * DIG_W;

    logic [DIG_W-1:0] r_a;
    logic [DIG_W-1:0] r_s;
    logic [DIG_W-1:0] r_c;
    logic [ACC_W-1:0] acc;

    // word product plus own carry plus the partial sum handed down by the upper neighbor
    assign acc = ACC_W'(r_a) * ACC_W'(i_b_dig) + ACC_W'(r_c) + ACC_W'(i_s_in);

    // load clears the partial sum, run advances one word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_a_dig;
            r_s <= '0;
            r_c <= '0;
        end else if (i_ctl.run) begin
            r_s <= acc[DIG_W-1:0];
            r_c <= acc[ACC_W-1:DIG_W];
        end
    end

    assign o_s = r_s;

endmodule

[hw/rtl/tss_mul.sv]
// magnitude multiplier: a row of word cells, product collection and rounding shift
module tss_mul
    import tss_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_ctl         i_ctl,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    output logic             o_done,
    output logic [MAG_W-1:0] o_mag
);

    localparam int CAP_LAST  = 2 * NUM_CELLS;
    localparam int LAST_STEP = CAP_LAST + 1;
    localparam int STEP_W    = $clog2(LAST_STEP + 1);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic                 r_done;
    logic                 r_sh;
    logic [OPND_W-1:0]    r_b;
    logic [PROD_W-1:0]    r_prod;
    logic [MAG_W-1:0]     r_mag;

    t_cell_ctl            cell_ctl;
    logic [OPND_W-1:0]    a_ext;
    logic [DIG_W-1:0]     s_link [NUM_CELLS+1];
    logic                 capture;
    logic                 last;

    logic [PROD_W-1:0]    shifted;
    logic                 rbit;
    logic [MAG_W:0]       inc;
    logic                 ovf;
    logic [MAG_W-1:0]     round_mag;

    assign a_ext          = {1'b0, i_a};
    assign cell_ctl.load  = i_ctl.start;
    assign cell_ctl.run   = r_busy;
    assign s_link[NUM_CELLS] = '0;

    // row of cells, partial sums move one cell down each cycle while the multiplier is busy
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        tss_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_a_dig (a_ext[k*DIG_W +: DIG_W]),
            .i_b_dig (r_b[DIG_W-1:0]),
            .i_s_in  (s_link[k+1]),
            .o_s     (s_link[k])
        );
    end

    assign capture = r_busy && (r_step != '0) && (r_step <= STEP_W'(CAP_LAST));
    assign last    = r_busy && (r_step == STEP_W'(LAST_STEP));

    // round to nearest on the magnitude, saturate above the internal range
    always_comb begin
        if (r_sh) begin
            shifted = r_prod >> RECIP_BITS;
            rbit    = r_prod[RECIP_BITS-1];
        end else begin
            shifted = r_prod >> FRAC_BITS;
            rbit    = r_prod[FRAC_BITS-1];
        end
        inc       = {1'b0, shifted[MAG_W-1:0]} + {{MAG_W{1'b0}}, rbit};
        ovf       = (|shifted[PROD_W-1:MAG_W]) | inc[MAG_W];
        round_mag = ovf ? {MAG_W{1'b1}} : inc[MAG_W-1:0];
    end

    // step counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= last;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operand word feed, product words collected low word first, result
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_b  <= {1'b0, i_b};
            r_sh <= i_ctl.recip_sh;
        end else if (r_busy) begin
            r_b <= r_b >> DIG_W;
        end
        if (capture) begin
            r_prod <= {s_link[0], r_prod[PROD_W-1:DIG_W]};
        end
        if (last) begin
            r_mag <= round_mag;
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_mag;

endmodule

[hw/rtl/tss_chk.sv]
// port checker for the taylor series sine block, bound to the top level
module tss_chk
    import tss_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] o_sine_value
);

    // a stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sine_value))
        else $error("result dropped or changed while stalled");

    // an input transfer starts work, so the block stops taking items
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second input transfer while an item is in work");

    // a new result appears only as the sequencer returns to idle
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while the sequencer is still busy");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind taylor_series_sine tss_chk u_tss_chk (.*);
